// ===== design/one_wire_temp_sensor_reader_defines.svh =====
// Assertion helpers for the top-level design file.
`ifndef ONE_WIRE_TEMP_SENSOR_READER_DEFINES_SVH
`define ONE_WIRE_TEMP_SENSOR_READER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OWTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/owtr_pkg.sv =====
`timescale 1ns / 1ps

package owtr_pkg;

    localparam int TIMER_WIDTH_DEF = 10;
    localparam int BYTE_BITS       = 8;
    localparam int CFG_REGS        = 8;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_CONVERT = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // Sensor command bytes.
    localparam logic [BYTE_BITS-1:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [BYTE_BITS-1:0] CMD_CONVERT  = 8'h44;
    localparam logic [BYTE_BITS-1:0] CMD_READ_PAD = 8'hBE;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RESET_LOW_TIME   = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT    = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL       = 3'd2;
    localparam logic [2:0] REG_SLOT_START       = 3'd3;
    localparam logic [2:0] REG_READ_SAMPLE_WAIT = 3'd4;
    localparam logic [2:0] REG_READ_TAIL        = 3'd5;
    localparam logic [2:0] REG_WRITE_SLOT       = 3'd6;
    localparam logic [2:0] REG_WRITE_GAP        = 3'd7;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_wait;
        logic [9:0] reset_tail;
        logic [3:0] slot_start;
        logic [3:0] read_sample_wait;
        logic [9:0] read_tail;
        logic [9:0] write_slot;
        logic [3:0] write_gap;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_low_time:   10'd870,
        presence_wait:    10'd80,
        reset_tail:       10'd400,
        slot_start:       4'd2,
        read_sample_wait: 4'd6,
        read_tail:        10'd52,
        write_slot:       10'd63,
        write_gap:        4'd2
    };

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       ok;
        logic       req_rejected;
        logic [3:0] temp_fraction;
        logic [7:0] temp_integer;
    } res_t;

endpackage

// ===== design/owtr_seq.sv =====
`timescale 1ns / 1ps

// Bus sequencer: holds the one-wire state and works out, from the state and the
// item being accepted, both the next state and the result of that item.
module owtr_seq #(
    parameter int TIMER_WIDTH = owtr_pkg::TIMER_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [1:0]         req_type,
    input  logic               line_level,
    input  owtr_pkg::cfg_t     cfg,
    output owtr_pkg::res_t     res
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_HIGH  = 4'd5;
    localparam logic [3:0] PH_RD_LOW   = 4'd6;
    localparam logic [3:0] PH_RD_WAIT  = 4'd7;
    localparam logic [3:0] PH_RD_TAIL  = 4'd8;

    localparam int BB = owtr_pkg::BYTE_BITS;
    localparam logic [2:0] LAST_BIT = 3'(BB - 1);

    logic [3:0]             phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] tick_reg, tick_next;
    logic [2:0]             bit_reg, bit_next;
    logic [BB-1:0]          shifter_reg, shifter_next;
    logic [1:0]             byte_step_reg, byte_step_next;
    logic [BB-1:0]          low_byte_reg, low_byte_next;
    logic                   is_read_reg, is_read_next;
    logic                   presence_reg, presence_next;
    logic [3:0]             frac_reg, frac_next;
    logic [7:0]             int_reg, int_next;

    logic [9:0]             dur_sel;
    logic [TIMER_WIDTH-1:0] dur;
    logic [TIMER_WIDTH:0]   tick_inc;
    logic                   over;
    logic                   byte_done;
    logic [2:0]             bit_adv;
    logic                   done;
    logic                   rejected;
    logic                   cur_bit;

    assign cur_bit = shifter_reg[0];

    // Length of the phase in progress, cut to TIMER_WIDTH bits; the timer returns to zero at each phase end.
    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:  dur_sel = cfg.reset_low_time;
            PH_RST_WAIT: dur_sel = cfg.presence_wait;
            PH_RST_TAIL: dur_sel = cfg.reset_tail;
            PH_WR_LOW:   dur_sel = cur_bit ? 10'(cfg.slot_start) : cfg.write_slot;
            PH_WR_HIGH:  dur_sel = cur_bit ? cfg.write_slot : 10'(cfg.write_gap);
            PH_RD_LOW:   dur_sel = 10'(cfg.slot_start);
            PH_RD_WAIT:  dur_sel = 10'(cfg.read_sample_wait);
            PH_RD_TAIL:  dur_sel = cfg.read_tail;
            default:     dur_sel = '0;
        endcase
    end

    assign dur       = TIMER_WIDTH'(dur_sel);
    assign tick_inc  = {1'b0, tick_reg} + (TIMER_WIDTH + 1)'(1);
    assign over      = tick_inc >= {1'b0, dur};
    assign byte_done = bit_reg >= LAST_BIT;
    assign bit_adv   = byte_done ? 3'd0 : bit_reg + 3'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shifter_next   = shifter_reg;
        byte_step_next = byte_step_reg;
        low_byte_next  = low_byte_reg;
        is_read_next   = is_read_reg;
        presence_next  = presence_reg;
        frac_next      = frac_reg;
        int_next       = int_reg;
        done           = 1'b0;
        rejected       = 1'b0;

        if (req_type == owtr_pkg::REQ_TICK)
        begin
            if (!over)
            begin
                tick_next = tick_inc[TIMER_WIDTH-1:0];
            end
            else
            begin
                tick_next = '0;
                unique case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        presence_next = !line_level;
                        phase_next    = PH_RST_TAIL;
                    end
                    PH_RST_TAIL:
                    begin
                        if (!presence_reg)
                        begin
                            frac_next  = '0;
                            int_next   = '0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            shifter_next   = owtr_pkg::CMD_SKIP_ROM;
                            bit_next       = '0;
                            byte_step_next = 2'd0;
                            phase_next     = PH_WR_LOW;
                        end
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_HIGH;
                    end
                    PH_WR_HIGH:
                    begin
                        shifter_next = shifter_reg >> 1;
                        bit_next     = bit_adv;
                        if (!byte_done)
                        begin
                            phase_next = PH_WR_LOW;
                        end
                        else if (byte_step_reg == 2'd0)
                        begin
                            // Second command byte depends on the request.
                            byte_step_next = 2'd1;
                            shifter_next   = is_read_reg ? owtr_pkg::CMD_READ_PAD
                                                         : owtr_pkg::CMD_CONVERT;
                            phase_next     = PH_WR_LOW;
                        end
                        else if (!is_read_reg)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            byte_step_next = 2'd2;
                            shifter_next   = '0;
                            phase_next     = PH_RD_LOW;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_WAIT;
                    end
                    PH_RD_WAIT:
                    begin
                        // Bits arrive least significant first.
                        shifter_next = {line_level, shifter_reg[BB-1:1]};
                        phase_next   = PH_RD_TAIL;
                    end
                    PH_RD_TAIL:
                    begin
                        bit_next = bit_adv;
                        if (!byte_done)
                        begin
                            phase_next = PH_RD_LOW;
                        end
                        else if (byte_step_reg == 2'd2)
                        begin
                            low_byte_next  = shifter_reg;
                            byte_step_next = 2'd3;
                            shifter_next   = '0;
                            phase_next     = PH_RD_LOW;
                        end
                        else
                        begin
                            frac_next  = low_byte_reg[3:0];
                            int_next   = {shifter_reg[3:0], low_byte_reg[7:4]};
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        // An idle tick leaves everything as it is.
                        tick_next = tick_reg;
                    end
                endcase
            end
        end
        else if (req_type == owtr_pkg::REQ_CONVERT || req_type == owtr_pkg::REQ_READ)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                is_read_next   = req_type == owtr_pkg::REQ_READ;
                presence_next  = 1'b0;
                bit_next       = '0;
                byte_step_next = 2'd0;
                shifter_next   = '0;
                phase_next     = PH_RST_LOW;
                tick_next      = '0;
            end
        end
    end

    always_comb
    begin
        res.drive_low     = phase_next == PH_RST_LOW || phase_next == PH_WR_LOW
                            || phase_next == PH_RD_LOW;
        res.busy_res      = phase_next != PH_IDLE;
        res.done_res      = done;
        res.ok            = presence_next;
        res.req_rejected  = rejected;
        res.temp_fraction = frac_next;
        res.temp_integer  = int_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shifter_reg   <= '0;
            byte_step_reg <= '0;
            low_byte_reg  <= '0;
            is_read_reg   <= 1'b0;
            presence_reg  <= 1'b0;
            frac_reg      <= '0;
            int_reg       <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shifter_reg   <= shifter_next;
            byte_step_reg <= byte_step_next;
            low_byte_reg  <= low_byte_next;
            is_read_reg   <= is_read_next;
            presence_reg  <= presence_next;
            frac_reg      <= frac_next;
            int_reg       <= int_next;
        end
    end

endmodule

// ===== design/one_wire_temp_sensor_reader.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// -------   --------------------   -------------------------------------------------
// input     in_valid / in_ready    req_type, line_level
// output    out_valid / out_ready  drive_low, busy_res, done_res, ok, req_rejected,
//                                  temp_fraction, temp_integer
// config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// Every item (tick or request) is taken when in_valid and in_ready are both high,
// and its result is registered; a new item can be taken in every cycle that in_ready is high.
// The result goes through an output register backed by a skid register, so
// in_ready only drops when both hold results that out_ready has not taken.
// Reset returns the sequencer to idle, empties the output stage and loads the
// timing registers with their defaults.
`include "one_wire_temp_sensor_reader_defines.svh"

module one_wire_temp_sensor_reader #(
    parameter int TIMER_WIDTH = owtr_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic                            line_level,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            drive_low,
    output logic                            busy_res,
    output logic                            done_res,
    output logic                            ok,
    output logic                            req_rejected,
    output logic [3:0]                      temp_fraction,
    output logic [7:0]                      temp_integer,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owtr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [owtr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [owtr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    owtr_pkg::cfg_t cfg_reg, cfg_next;
    owtr_pkg::res_t new_res;
    owtr_pkg::res_t out_res_reg, out_res_next;
    owtr_pkg::res_t skid_res_reg, skid_res_next;
    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    logic           in_fire;
    logic           cfg_write;
    logic [2:0]     reg_index;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[owtr_pkg::APB_ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                owtr_pkg::REG_RESET_LOW_TIME:   cfg_next.reset_low_time   = pwdata[9:0];
                owtr_pkg::REG_PRESENCE_WAIT:    cfg_next.presence_wait    = pwdata[9:0];
                owtr_pkg::REG_RESET_TAIL:       cfg_next.reset_tail       = pwdata[9:0];
                owtr_pkg::REG_SLOT_START:       cfg_next.slot_start       = pwdata[3:0];
                owtr_pkg::REG_READ_SAMPLE_WAIT: cfg_next.read_sample_wait = pwdata[3:0];
                owtr_pkg::REG_READ_TAIL:        cfg_next.read_tail        = pwdata[9:0];
                owtr_pkg::REG_WRITE_SLOT:       cfg_next.write_slot       = pwdata[9:0];
                owtr_pkg::REG_WRITE_GAP:        cfg_next.write_gap        = pwdata[3:0];
                default:                        cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            owtr_pkg::REG_RESET_LOW_TIME:   prdata = 32'(cfg_reg.reset_low_time);
            owtr_pkg::REG_PRESENCE_WAIT:    prdata = 32'(cfg_reg.presence_wait);
            owtr_pkg::REG_RESET_TAIL:       prdata = 32'(cfg_reg.reset_tail);
            owtr_pkg::REG_SLOT_START:       prdata = 32'(cfg_reg.slot_start);
            owtr_pkg::REG_READ_SAMPLE_WAIT: prdata = 32'(cfg_reg.read_sample_wait);
            owtr_pkg::REG_READ_TAIL:        prdata = 32'(cfg_reg.read_tail);
            owtr_pkg::REG_WRITE_SLOT:       prdata = 32'(cfg_reg.write_slot);
            owtr_pkg::REG_WRITE_GAP:        prdata = 32'(cfg_reg.write_gap);
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= owtr_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    owtr_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .req_type   (req_type),
        .line_level (line_level),
        .cfg        (cfg_reg),
        .res        (new_res)
    );

    // Output register with skid register behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_res_next   = new_res;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid     = out_valid_reg;
    assign drive_low     = out_res_reg.drive_low;
    assign busy_res      = out_res_reg.busy_res;
    assign done_res      = out_res_reg.done_res;
    assign ok            = out_res_reg.ok;
    assign req_rejected  = out_res_reg.req_rejected;
    assign temp_fraction = out_res_reg.temp_fraction;
    assign temp_integer  = out_res_reg.temp_integer;

    // Checks
    `OWTR_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid register holds a result while the output register is empty")
    `OWTR_ASSERT_NEXT(a_transfer_gives_result, in_fire, out_valid_reg,
        "accepted transfer left no result in the output register")
    `OWTR_ASSERT_NOW(a_drive_only_when_busy, out_valid_reg && out_res_reg.drive_low,
        out_res_reg.busy_res, "bus driven low outside a sequence")
    `OWTR_ASSERT_NOW(a_done_ends_sequence, out_valid_reg && out_res_reg.done_res,
        !out_res_reg.busy_res && !out_res_reg.req_rejected,
        "sequence reported done while still busy or rejecting")

endmodule
